[sv/arpc_pkg.sv]
// shared types, constants and codes for the arp cache with request retry
`default_nettype none
package arpc_pkg;

    localparam int CacheEntriesDefault   = 64;
    localparam int PendingEntriesDefault = 8;
    localparam int QueueDepth            = 2;

    localparam logic [15:0] CacheTimeoutReset  = 16'd15;
    localparam logic [2:0]  RetryLimitReset    = 3'd5;
    localparam logic [7:0]  RetryIntervalReset = 8'd1;

    typedef enum logic [1:0] {
        OP_LOOKUP = 2'd0,
        OP_REPLY  = 2'd1,
        OP_TICK   = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        K_HIT       = 3'd0,
        K_SEND      = 3'd1,
        K_GIVEUP    = 3'd2,
        K_WAIT      = 3'd3,
        K_RELEASED  = 3'd4,
        K_UNMATCHED = 3'd5,
        K_TICKDONE  = 3'd6,
        K_PENDFULL  = 3'd7
    } kind_t;

    typedef enum logic [1:0] {
        REG_TIMEOUT  = 2'd0,
        REG_LIMIT    = 2'd1,
        REG_INTERVAL = 2'd2,
        REG_UNUSED   = 2'd3
    } reg_t;

    typedef struct packed {
        op_t         op;
        logic [31:0] ip;
        logic [47:0] mac;
    } cmd_t;

    typedef struct packed {
        kind_t       kind;
        logic [31:0] ip;
        logic [47:0] mac;
        logic        stored;
        logic        last;
    } res_t;

    typedef struct packed {
        logic [15:0] cache_timeout;
        logic [2:0]  retry_limit;
        logic [7:0]  retry_interval;
    } cfg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CSCAN,
        ST_CREAD,
        ST_CPICK,
        ST_CHIT,
        ST_PSCAN,
        ST_PDECIDE,
        ST_REPLY_OUT,
        ST_TAGE,
        ST_TAGE_WR,
        ST_TPEND,
        ST_TDONE,
        ST_EMIT
    } state_t;

endpackage
`default_nettype wire

[sv/arpc_front.sv]
// input front: drops unused opcodes and queues commands for the engine
`default_nettype none
module arpc_front (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire arpc_pkg::cmd_t in_cmd,
    output logic               q_valid,
    input  wire logic          q_ready,
    output arpc_pkg::cmd_t     q_cmd
);
    import arpc_pkg::*;

    localparam int AW = $clog2(QueueDepth);

    cmd_t           mem_reg [QueueDepth];
    logic [AW-1:0]  wr_reg, rd_reg;
    logic [AW:0]    cnt_reg;
    logic           push, pop;

    assign in_ready = (cnt_reg != (AW+1)'(QueueDepth));
    assign push     = in_valid && in_ready && (in_cmd.op != OP_NONE);
    assign q_valid  = (cnt_reg != '0);
    assign pop      = q_valid && q_ready;
    assign q_cmd    = mem_reg[rd_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_reg] <= in_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) begin
                wr_reg <= (wr_reg == AW'(QueueDepth - 1)) ? '0 : wr_reg + 1'b1;
            end
            if (pop) begin
                rd_reg <= (rd_reg == AW'(QueueDepth - 1)) ? '0 : rd_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
    end
endmodule
`default_nettype wire

[sv/arpc_engine.sv]
// back engine: lookup and reply scan cache and pending table one entry a cycle
`default_nettype none
module arpc_engine #(
    parameter int CACHE_ENTRIES   = arpc_pkg::CacheEntriesDefault,
    parameter int PENDING_ENTRIES = arpc_pkg::PendingEntriesDefault
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire arpc_pkg::cfg_t cfg,
    input  wire logic           q_valid,
    output logic                q_ready,
    input  wire arpc_pkg::cmd_t q_cmd,
    output logic                r_valid,
    input  wire logic           r_ready,
    output arpc_pkg::res_t      r_res,
    output logic                busy
);
    import arpc_pkg::*;

    localparam int CW = $clog2(CACHE_ENTRIES);
    localparam int PW = (PENDING_ENTRIES > 1) ? $clog2(PENDING_ENTRIES) : 1;

    // cache payload memories, one read port and one write port each
    logic [31:0] c_addr_mem [CACHE_ENTRIES];
    logic [47:0] c_hw_mem   [CACHE_ENTRIES];
    logic [15:0] c_age_mem  [CACHE_ENTRIES];
    logic [CACHE_ENTRIES-1:0] c_valid_reg;

    logic [PENDING_ENTRIES-1:0] p_valid_reg;
    logic [31:0] p_addr_reg  [PENDING_ENTRIES];
    logic [2:0]  p_tries_reg [PENDING_ENTRIES];
    logic [7:0]  p_since_reg [PENDING_ENTRIES];

    state_t      state_reg, state_next;
    cmd_t        cmd_reg;
    logic [CW:0] ci_reg;
    logic [PW:0] pi_reg;
    logic        hit_reg;
    logic [CW-1:0] hit_idx_reg;
    logic        pfound_reg;
    logic [PW-1:0] pidx_reg;
    logic        pfree_reg;
    logic        cfree_reg;
    logic [CW-1:0] cfree_idx_reg;
    logic [31:0] rd_addr_reg;
    logic [47:0] rd_hw_reg;
    logic [15:0] rd_age_reg;
    logic        rd_valid_reg;
    logic [CW-1:0] rd_idx_reg;
    res_t        res_reg;
    logic        rv_reg;
    state_t      ret_reg;

    logic [CW-1:0] ci;
    logic [CW-1:0] rd_ptr;
    logic [PW-1:0] pi;
    logic [15:0]   age_inc;
    logic [2:0]    tr;
    logic [7:0]    sn;
    logic          fire, giveup;
    logic          pd_fire, pd_give, tp_give;
    kind_t         pd_kind, tp_kind;

    assign ci      = ci_reg[CW-1:0];
    assign pi      = pi_reg[PW-1:0];
    assign q_ready = (state_reg == ST_IDLE);
    assign busy    = (state_reg != ST_IDLE);
    assign r_valid = rv_reg;
    assign r_res   = res_reg;
    assign age_inc = (rd_age_reg == 16'hFFFF) ? rd_age_reg : rd_age_reg + 16'd1;
    assign tr      = p_tries_reg[pidx_reg];
    assign sn      = p_since_reg[pidx_reg];
    assign fire    = (tr == 3'd0) || (sn > cfg.retry_interval);
    assign giveup  = tr >= cfg.retry_limit;
    // a freshly allocated slot (no match found) always fires
    assign pd_fire = !pfound_reg || fire;
    assign pd_give = pfound_reg ? giveup : (cfg.retry_limit == 3'd0);
    assign tp_give = p_tries_reg[pi] >= cfg.retry_limit;
    // after the scan the winning hit slot is read once more for its mac
    assign rd_ptr  = (state_reg == ST_CPICK) ? hit_idx_reg : ci;

    always_comb begin
        pd_kind = K_PENDFULL;
        if (pfound_reg || pfree_reg) begin
            if (!pd_fire) begin
                pd_kind = K_WAIT;
            end else if (pd_give) begin
                pd_kind = K_GIVEUP;
            end else begin
                pd_kind = K_SEND;
            end
        end
        if (tp_give) begin
            tp_kind = K_GIVEUP;
        end else begin
            tp_kind = K_SEND;
        end
    end

    // registered read of the cache memories
    always_ff @(posedge aclk) begin
        rd_addr_reg  <= c_addr_mem[rd_ptr];
        rd_hw_reg    <= c_hw_mem[rd_ptr];
        rd_age_reg   <= c_age_mem[rd_ptr];
        rd_valid_reg <= c_valid_reg[rd_ptr];
        rd_idx_reg   <= rd_ptr;
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_REPLY_OUT && cfree_reg) begin
            c_addr_mem[cfree_idx_reg] <= cmd_reg.ip;
            c_hw_mem[cfree_idx_reg]   <= cmd_reg.mac;
            c_age_mem[cfree_idx_reg]  <= '0;
        end else if (state_reg == ST_TAGE_WR && rd_valid_reg) begin
            c_age_mem[rd_idx_reg] <= age_inc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    state_next = (q_cmd.op == OP_TICK) ? ST_TAGE : ST_CSCAN;
                end
            end
            ST_CSCAN: begin
                if (ci_reg == (CW+1)'(CACHE_ENTRIES - 1)) begin
                    state_next = ST_CREAD;
                end
            end
            ST_CREAD:     state_next = ST_CPICK;
            ST_CPICK: begin
                state_next = (cmd_reg.op == OP_LOOKUP && hit_reg) ? ST_CHIT : ST_PSCAN;
            end
            ST_CHIT:      state_next = ST_EMIT;
            ST_PSCAN: begin
                if (pi_reg == (PW+1)'(PENDING_ENTRIES - 1)) begin
                    state_next = (cmd_reg.op == OP_REPLY) ? ST_REPLY_OUT : ST_PDECIDE;
                end
            end
            ST_PDECIDE:   state_next = ST_EMIT;
            ST_REPLY_OUT: state_next = ST_EMIT;
            ST_TAGE:      state_next = ST_TAGE_WR;
            ST_TAGE_WR: begin
                state_next = (ci_reg == (CW+1)'(CACHE_ENTRIES)) ? ST_TPEND : ST_TAGE;
            end
            ST_TPEND: begin
                if (pi_reg == (PW+1)'(PENDING_ENTRIES)) begin
                    state_next = ST_TDONE;
                end else if (p_valid_reg[pi] &&
                             ((p_tries_reg[pi] == 3'd0) ||
                              (p_since_reg[pi] > cfg.retry_interval))) begin
                    state_next = ST_EMIT;
                end
            end
            ST_TDONE:     state_next = ST_EMIT;
            ST_EMIT: begin
                if (r_ready) begin
                    state_next = ret_reg;
                end
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= '0;
            p_valid_reg <= '0;
            rv_reg      <= 1'b0;
            ret_reg     <= ST_IDLE;
        end else begin
            if (rv_reg && r_ready) begin
                rv_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    cmd_reg    <= q_cmd;
                    ci_reg     <= '0;
                    pi_reg     <= '0;
                    hit_reg    <= 1'b0;
                    pfound_reg <= 1'b0;
                    pfree_reg  <= 1'b0;
                    cfree_reg  <= 1'b0;
                end
                ST_CSCAN: begin
                    ci_reg <= ci_reg + 1'b1;
                end
                ST_CREAD: begin
                    ci_reg <= '0;
                end
                ST_PSCAN: begin
                    pi_reg <= pi_reg + 1'b1;
                end
                ST_PDECIDE: begin
                    ret_reg <= ST_IDLE;
                    rv_reg  <= 1'b1;
                    res_reg <= '{kind: pd_kind, ip: cmd_reg.ip, mac: '0,
                                 stored: 1'b0, last: 1'b1};
                    if (pfound_reg || pfree_reg) begin
                        p_valid_reg[pidx_reg] <= !(pd_fire && pd_give);
                        if (!pfound_reg) begin
                            p_addr_reg[pidx_reg] <= cmd_reg.ip;
                        end
                        if (pd_fire && !pd_give) begin
                            p_since_reg[pidx_reg] <= '0;
                            p_tries_reg[pidx_reg] <= pfound_reg ? tr + 3'd1 : 3'd1;
                        end
                    end
                end
                ST_REPLY_OUT: begin
                    ret_reg <= ST_IDLE;
                    rv_reg  <= 1'b1;
                    res_reg <= '{kind: pfound_reg ? K_RELEASED : K_UNMATCHED,
                                 ip: cmd_reg.ip, mac: '0, stored: cfree_reg, last: 1'b1};
                    if (pfound_reg) begin
                        p_valid_reg[pidx_reg] <= 1'b0;
                    end
                    if (cfree_reg) begin
                        c_valid_reg[cfree_idx_reg] <= 1'b1;
                    end
                end
                ST_CHIT: begin
                    ret_reg <= ST_IDLE;
                    rv_reg  <= 1'b1;
                    res_reg <= '{kind: K_HIT, ip: cmd_reg.ip, mac: rd_hw_reg,
                                 stored: 1'b0, last: 1'b1};
                end
                ST_TAGE: begin
                    ci_reg <= ci_reg + 1'b1;
                end
                ST_TAGE_WR: begin
                    if (rd_valid_reg && (age_inc > cfg.cache_timeout)) begin
                        c_valid_reg[rd_idx_reg] <= 1'b0;
                    end
                    if (ci_reg == (CW+1)'(CACHE_ENTRIES)) begin
                        for (int k = 0; k < PENDING_ENTRIES; k++) begin
                            if (p_valid_reg[k] && p_since_reg[k] != 8'hFF) begin
                                p_since_reg[k] <= p_since_reg[k] + 8'd1;
                            end
                        end
                    end
                end
                ST_TPEND: begin
                    if (pi_reg != (PW+1)'(PENDING_ENTRIES)) begin
                        pi_reg <= pi_reg + 1'b1;
                        if (p_valid_reg[pi] &&
                            ((p_tries_reg[pi] == 3'd0) ||
                             (p_since_reg[pi] > cfg.retry_interval))) begin
                            ret_reg <= ST_TPEND;
                            rv_reg  <= 1'b1;
                            res_reg <= '{kind: tp_kind, ip: p_addr_reg[pi], mac: '0,
                                         stored: 1'b0, last: 1'b0};
                            if (tp_give) begin
                                p_valid_reg[pi] <= 1'b0;
                            end else begin
                                p_since_reg[pi] <= '0;
                                p_tries_reg[pi] <= p_tries_reg[pi] + 3'd1;
                            end
                        end
                    end
                end
                ST_TDONE: begin
                    ret_reg <= ST_IDLE;
                    rv_reg  <= 1'b1;
                    res_reg <= '{kind: K_TICKDONE, ip: '0, mac: '0,
                                 stored: 1'b0, last: 1'b1};
                end
                default: begin
                end
            endcase
            // scan compare on the registered read, which trails the index by the read register
            if (state_reg == ST_CSCAN || state_reg == ST_CREAD) begin
                if (state_reg == ST_CREAD || ci_reg != '0) begin
                    if (rd_valid_reg && rd_addr_reg == cmd_reg.ip) begin
                        hit_reg     <= 1'b1;
                        hit_idx_reg <= rd_idx_reg;
                    end
                    if (!rd_valid_reg && !cfree_reg) begin
                        cfree_reg     <= 1'b1;
                        cfree_idx_reg <= rd_idx_reg;
                    end
                end
            end
            if (state_reg == ST_PSCAN) begin
                if (p_valid_reg[pi] && p_addr_reg[pi] == cmd_reg.ip && !pfound_reg) begin
                    pfound_reg <= 1'b1;
                    pidx_reg   <= pi;
                end else if (!p_valid_reg[pi] && !pfree_reg && !pfound_reg) begin
                    pfree_reg <= 1'b1;
                    pidx_reg  <= pi;
                end
            end
        end
    end
endmodule
`default_nettype wire

[sv/arp_cache_with_request_retry.sv]
// top level of the arp cache with request retry
// usage:
// - slave stream: tdata {mac[79:32], ip[31:0]}, tuser is the
//   opcode (lookup, reply, tick); opcode 3 transfers are taken and dropped
// - master stream: tdata {mac_res, ip_res} at [79:0], tuser {cache_stored, kind},
//   tlast marks the final result of one input
// - apb port: cache_timeout at 0x0, retry_limit at 0x4, retry_interval at 0x8
// - a two entry command queue decouples acceptance from the scan engine
// - lookup and reply walk all cache slots through a registered memory read,
//   then every pending slot, except that a lookup hit skips the pending slots
// - a tick reads each cache slot, writes back the age of each valid one, then
//   checks each pending slot in turn, sends a result per due one, tick done last
// - the engine works one command at a time and takes the next one the cycle
//   after the final result transfer; the result register holds while
//   m_axis_tready is low, the engine waits and the queue fills up
// - reset clears all valid bits and sets the registers to defaults
`default_nettype none
module arp_cache_with_request_retry #(
    parameter int CACHE_ENTRIES   = arpc_pkg::CacheEntriesDefault,
    parameter int PENDING_ENTRIES = arpc_pkg::PendingEntriesDefault
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [79:0] s_axis_tdata,   // ip, mac
    input  wire logic [1:0]  s_axis_tuser,   // opcode
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [79:0]      m_axis_tdata,   // ip_res, mac_res
    output logic [3:0]       m_axis_tuser,   // kind, cache_stored
    output logic             m_axis_tlast,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import arpc_pkg::*;

    cfg_t cfg_reg;
    cmd_t in_cmd, q_cmd;
    res_t res;
    logic q_valid, q_ready, busy;
    reg_t widx;

    assign in_cmd = '{op: op_t'(s_axis_tuser), ip: s_axis_tdata[31:0],
                      mac: s_axis_tdata[79:32]};
    assign pready = 1'b1;
    assign widx   = reg_t'(paddr[3:2]);

    // register writes on the access cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{cache_timeout: CacheTimeoutReset, retry_limit: RetryLimitReset,
                         retry_interval: RetryIntervalReset};
        end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
            unique case (widx)
                REG_TIMEOUT:  cfg_reg.cache_timeout  <= pwdata[15:0];
                REG_LIMIT:    cfg_reg.retry_limit    <= pwdata[2:0];
                REG_INTERVAL: cfg_reg.retry_interval <= pwdata[7:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (widx)
            REG_TIMEOUT:  prdata = {16'd0, cfg_reg.cache_timeout};
            REG_LIMIT:    prdata = {29'd0, cfg_reg.retry_limit};
            REG_INTERVAL: prdata = {24'd0, cfg_reg.retry_interval};
            default:      prdata = '0;
        endcase
    end

    arpc_front u_front (
        .aclk, .aresetn,
        .in_valid (s_axis_tvalid), .in_ready (s_axis_tready), .in_cmd (in_cmd),
        .q_valid, .q_ready, .q_cmd
    );

    arpc_engine #(
        .CACHE_ENTRIES   (CACHE_ENTRIES),
        .PENDING_ENTRIES (PENDING_ENTRIES)
    ) u_engine (
        .aclk, .aresetn, .cfg (cfg_reg),
        .q_valid, .q_ready, .q_cmd,
        .r_valid (m_axis_tvalid), .r_ready (m_axis_tready), .r_res (res), .busy
    );

    assign m_axis_tdata = {res.mac, res.ip};
    assign m_axis_tuser = {res.stored, res.kind};
    assign m_axis_tlast = res.last;

    // a result only appears while the engine works on a command
    a_res_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> busy) else $error("result without active command");

    // tick done always closes the results of its tick
    a_kind_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && res.kind == K_TICKDONE) |-> res.last)
        else $error("tick done not last");

    // engine only takes a command when idle, and is busy once it has taken it
    a_take: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_valid && q_ready) |=> busy) else $error("command not taken");
endmodule
`default_nettype wire

[tb/sv/tb_arp_cache_with_request_retry.sv]
// self-checking stream testbench for the arp cache with request retry
module tb_arp_cache_with_request_retry;
    import arpc_pkg::*;

    localparam int NCACHE  = 64;
    localparam int NPEND   = 8;
    localparam int LIMIT   = 2_000_000;
    localparam int SETTLE  = 300;

    // cache and pending-table shadow with its own copy of the register values
    class arp_shadow;
        bit          c_vld[NCACHE];
        bit [31:0]   c_ip[NCACHE];
        bit [47:0]   c_mac[NCACHE];
        bit [15:0]   c_age[NCACHE];
        bit          p_vld[NPEND];
        bit [31:0]   p_ip[NPEND];
        bit [2:0]    p_tries[NPEND];
        bit [7:0]    p_since[NPEND];
        bit [15:0]   timeout_ticks;
        bit [2:0]    max_tries;
        bit [7:0]    resend_gap;
        res_t        awaited[$];
        int          errors;
        int          matched;

        function new();
            timeout_ticks = CacheTimeoutReset;
            max_tries     = RetryLimitReset;
            resend_gap    = RetryIntervalReset;
        endfunction

        function void push(kind_t k, bit [31:0] ip, bit [47:0] mac, bit st);
            res_t r;
            r.kind = k; r.ip = ip; r.mac = mac; r.stored = st; r.last = 1'b0;
            awaited.push_back(r);
        endfunction

        // retry decision for one live pending slot
        function kind_t retry_step(int p);
            if (p_tries[p] == 0 || p_since[p] > resend_gap) begin
                if (p_tries[p] >= max_tries) begin
                    p_vld[p] = 1'b0;
                    return K_GIVEUP;
                end
                p_since[p] = 0;
                p_tries[p] = p_tries[p] + 3'd1;
                return K_SEND;
            end
            return K_WAIT;
        endfunction

        function void take_command(op_t op, bit [31:0] ip, bit [47:0] mac);
            int hit, p, n_before;
            bit st;
            kind_t k;
            hit = -1; p = -1; st = 0;
            n_before = awaited.size();
            case (op)
                OP_LOOKUP: begin
                    for (int i = 0; i < NCACHE; i++)
                        if (c_vld[i] && c_ip[i] == ip) hit = i;
                    if (hit >= 0) begin
                        push(K_HIT, ip, c_mac[hit], 0);
                    end else begin
                        for (int i = NPEND - 1; i >= 0; i--)
                            if (p_vld[i] && p_ip[i] == ip) p = i;
                        if (p < 0) begin
                            for (int i = NPEND - 1; i >= 0; i--)
                                if (!p_vld[i]) p = i;
                            if (p >= 0) begin
                                p_vld[p] = 1; p_ip[p] = ip; p_tries[p] = 0; p_since[p] = 0;
                            end
                        end
                        if (p < 0) push(K_PENDFULL, ip, 0, 0);
                        else       push(retry_step(p), ip, 0, 0);
                    end
                end
                OP_REPLY: begin
                    k = K_UNMATCHED;
                    for (int i = NPEND - 1; i >= 0; i--)
                        if (p_vld[i] && p_ip[i] == ip) p = i;
                    if (p >= 0) begin
                        p_vld[p] = 0;
                        k = K_RELEASED;
                    end
                    for (int i = 0; i < NCACHE && !st; i++) begin
                        if (!c_vld[i]) begin
                            c_vld[i] = 1; c_ip[i] = ip; c_mac[i] = mac; c_age[i] = 0; st = 1;
                        end
                    end
                    push(k, ip, 0, st);
                end
                OP_TICK: begin
                    for (int i = 0; i < NCACHE; i++) begin
                        if (c_vld[i]) begin
                            if (c_age[i] != 16'hffff) c_age[i]++;
                            if (c_age[i] > timeout_ticks) c_vld[i] = 0;
                        end
                    end
                    for (int i = 0; i < NPEND; i++)
                        if (p_vld[i] && p_since[i] != 8'hff) p_since[i]++;
                    for (int i = 0; i < NPEND; i++) begin
                        if (p_vld[i]) begin
                            k = retry_step(i);
                            if (k != K_WAIT) push(k, p_ip[i], 0, 0);
                        end
                    end
                    push(K_TICKDONE, 0, 0, 0);
                end
                default: ;
            endcase
            if (awaited.size() > n_before) awaited[$].last = 1'b1;
        endfunction

        function void match_result(res_t got);
            res_t want;
            if (awaited.size() == 0) begin
                $display("%0t: unexpected result kind=%0d ip=%h", $time, got.kind, got.ip);
                errors++;
                return;
            end
            want = awaited.pop_front();
            matched++;
            if (got !== want) begin
                $display("%0t: mismatch expected kind=%0d ip=%h mac=%h st=%b last=%b", $time,
                         want.kind, want.ip, want.mac, want.stored, want.last);
                $display("%0t:          actual   kind=%0d ip=%h mac=%h st=%b last=%b", $time,
                         got.kind, got.ip, got.mac, got.stored, got.last);
                errors++;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata;    // ip [31:0], mac [79:32]
    logic [1:0]  s_axis_tuser;    // opcode
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [79:0] m_axis_tdata;    // ip_res [31:0], mac_res [79:32]
    logic [3:0]  m_axis_tuser;    // kind [2:0], cache_stored [3]
    logic        m_axis_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    arp_shadow shadow;
    int        sender_idle_pct;
    int        sink_stall_pct;
    int        n_sent;
    longint    cycle_count;

    arp_cache_with_request_retry u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial aclk = 1'b0;
    always #2 aclk = ~aclk;

    // watchdog on total run length
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("status: fail");
            $finish;
        end
    end

    // result sink: random back-pressure, changed at the falling edge only
    always @(negedge aclk) begin
        m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // every accepted result transfer goes straight to the shadow check
    always @(posedge aclk) begin
        res_t got;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got.kind   = kind_t'(m_axis_tuser[2:0]);
            got.ip     = m_axis_tdata[31:0];
            got.mac    = m_axis_tdata[79:32];
            got.stored = m_axis_tuser[3];
            got.last   = m_axis_tlast;
            shadow.match_result(got);
        end
    end

    // one command transfer; called and returning at a falling edge
    task automatic send_cmd(op_t op, logic [31:0] ip, logic [47:0] mac);
        bit done;
        done = 0;
        if (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
            s_axis_tvalid = 1'b0;
            while ($urandom_range(99) < sender_idle_pct) @(negedge aclk);
            @(negedge aclk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = op;
        s_axis_tdata  = {mac, ip};
        while (!done) begin
            @(posedge aclk);
            done = s_axis_tready;
        end
        shadow.take_command(op, ip, mac);
        n_sent++;
        @(negedge aclk);
    endtask

    // apb write, setup then access phase
    task automatic write_reg(reg_t idx, logic [31:0] val);
        psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
        paddr = {idx, 2'b00}; pwdata = val;
        @(negedge aclk);
        penable = 1'b1;
        @(negedge aclk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
        case (idx)
            REG_TIMEOUT:  shadow.timeout_ticks = val[15:0];
            REG_LIMIT:    shadow.max_tries     = val[2:0];
            REG_INTERVAL: shadow.resend_gap    = val[7:0];
            default: ;
        endcase
    endtask

    // wait until the block has delivered everything, then let the engine settle
    task automatic drain();
        s_axis_tvalid = 1'b0;
        while (shadow.awaited.size() > 0) @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    task automatic set_regs(logic [15:0] tmo, logic [2:0] lim, logic [7:0] gap);
        drain();
        write_reg(REG_TIMEOUT, {16'd0, tmo});
        write_reg(REG_LIMIT, {29'd0, lim});
        write_reg(REG_INTERVAL, {24'd0, gap});
    endtask

    function automatic logic [47:0] rand_mac();
        return 48'({$urandom, $urandom});
    endfunction

    // small address pool so lookups, replies and retries keep meeting each other
    function automatic logic [31:0] pick_ip();
        if ($urandom_range(9) == 0) return $urandom;
        return 32'h0a00_0000 | $urandom_range(11);
    endfunction

    // one random phase: mostly lookups and replies on the pool, regular ticks
    task automatic random_phase(int count);
        int w;
        for (int n = 0; n < count; n++) begin
            w = $urandom_range(99);
            if (w < 45)      send_cmd(OP_LOOKUP, pick_ip(), rand_mac());
            else if (w < 70) send_cmd(OP_REPLY, pick_ip(), rand_mac());
            else if (w < 96) send_cmd(OP_TICK, $urandom, rand_mac());
            else             send_cmd(OP_NONE, $urandom, rand_mac());
        end
    endtask

    initial begin
        shadow          = new();
        cycle_count     = 0;
        n_sent          = 0;
        sender_idle_pct = 0;
        sink_stall_pct  = 0;
        aresetn         = 1'b0;
        s_axis_tvalid   = 1'b0;
        s_axis_tdata    = '0;
        s_axis_tuser    = OP_LOOKUP;
        m_axis_tready   = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        repeat (7) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // directed: field extremes, every opcode, full pending table, retries
        send_cmd(OP_LOOKUP, 32'h0000_0000, 48'h0);             // miss, first send
        send_cmd(OP_LOOKUP, 32'hffff_ffff, 48'hffff_ffff_ffff);
        send_cmd(OP_LOOKUP, 32'h0000_0000, 48'h0);             // still waiting
        send_cmd(OP_TICK, 32'h0, 48'h0);
        send_cmd(OP_TICK, 32'h0, 48'h0);                       // resend after interval
        send_cmd(OP_REPLY, 32'h0000_0000, 48'hffff_ffff_ffff); // released and stored
        send_cmd(OP_REPLY, 32'h1234_5678, 48'h0);              // unmatched
        send_cmd(OP_REPLY, 32'h1234_5678, 48'h5555_aaaa_5555); // duplicate, higher slot wins
        send_cmd(OP_LOOKUP, 32'h1234_5678, 48'h0);
        send_cmd(OP_LOOKUP, 32'h0000_0000, 48'h0);
        send_cmd(OP_NONE, 32'hdead_beef, 48'hffff_ffff_ffff);  // dropped silently
        for (int i = 1; i <= 8; i++)                           // fill pending, then overflow
            send_cmd(OP_LOOKUP, 32'hc0a8_0000 | i, 48'h0);
        for (int i = 0; i < 6; i++)                            // ticks resend the pending requests
            send_cmd(OP_TICK, 32'h0, 48'h0);

        // no idling; fill the cache past its capacity with a mapping that never ages out
        set_regs(16'hffff, 3'd7, 8'd0);
        for (int i = 0; i < NCACHE + 4; i++)
            send_cmd(OP_REPLY, 32'h0b00_0000 | i, rand_mac());
        for (int i = 0; i < 6; i++) send_cmd(OP_TICK, 32'h0, 48'h0);
        for (int i = 0; i < 8; i++)
            send_cmd(OP_LOOKUP, 32'h0b00_0000 | $urandom_range(NCACHE + 3), 48'h0);
        random_phase(40);

        // timeout 1 flushes the cache; sender idles heavily
        set_regs(16'd1, 3'd1, 8'd254);
        sender_idle_pct = 77;
        random_phase(40);

        // receiver stalls heavily
        set_regs(16'd3, 3'd3, 8'd2);
        sender_idle_pct = 0;
        sink_stall_pct  = 77;
        random_phase(40);

        // both sides idle now and then, registers at random legal values
        set_regs(16'($urandom_range(65535, 1)), 3'($urandom_range(7, 1)),
                 8'($urandom_range(254)));
        sender_idle_pct = 12;
        sink_stall_pct  = 12;
        random_phase(40);

        drain();
        $display("sent %0d commands, checked %0d results over five register settings",
                 n_sent, shadow.matched);
        if (shadow.errors == 0) begin
            $display("status: pass");
        end else begin
            $display("%0d errors", shadow.errors);
            $display("status: fail");
        end
        $finish;
    end

endmodule
